>>> sv/voice_channel_allocator_unit_macros.svh
// Assertion macros for the voice channel allocator.
// Taken in by the modules that carry concurrent checks; no other dependencies.
`ifndef VOICE_CHANNEL_ALLOCATOR_UNIT_MACROS_SVH
`define VOICE_CHANNEL_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VCA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define VCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/vca_pkg.sv
// Shared types and constants for the voice channel allocator.
// Used by vca_ctrl, vca_datapath and the top level; no dependencies.
package vca_pkg;

   localparam int CFG_W  = 5;
   localparam int CHAN_W = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

   typedef enum logic [1:0] {
      FUNC_START    = 2'd0,
      FUNC_STOP_SRC = 2'd1,
      FUNC_RELEASE  = 2'd2,
      FUNC_STOP_ALL = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_STOPPED  = 2'd0,
      KIND_GRANTED  = 2'd1,
      KIND_REJECTED = 2'd2,
      KIND_NO_ACTION = 2'd3
   } kind_type;

   typedef struct packed {
      func_type          func;
      logic [15:0]       source_id;
      logic [7:0]        sound_id;
      logic [7:0]        prio;
      logic [CHAN_W-1:0] chan_sel;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAN_W-1:0] chan_out;
      logic [7:0]        sound_out;
      logic              last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic match;
      logic stop_step;
      logic find;
      logic steal;
      logic grant;
      logic reject;
      logic noact;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic stop_any;
      logic stop_one;
      logic is_start;
      logic found;
      logic steal;
   } status_type;

endpackage

>>> sv/vca_ctrl.sv
// Sequencer for the voice channel allocator: one command item at a time.
// Depends on vca_pkg and the assertion macro header.
`include "voice_channel_allocator_unit_macros.svh"

module vca_ctrl import vca_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MATCH = 7'b0000010,
      ST_STOP  = 7'b0000100,
      ST_FIND  = 7'b0001000,
      ST_PICK  = 7'b0010000,
      ST_GRANT = 7'b0100000,
      ST_CLOSE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_STOP;
         end
         ST_STOP: begin
            if (status.stop_any) begin
               cmd.stop_step = 1'b1;
               if (status.stop_one) begin
                  state_in = status.is_start ? ST_FIND : ST_IDLE;
               end
            end else begin
               // nothing to stop at all
               state_in = status.is_start ? ST_FIND : ST_CLOSE;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (!status.found) begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.steal) begin
               cmd.steal = 1'b1;
               state_in  = ST_GRANT;
            end else begin
               cmd.grant = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_GRANT: begin
            cmd.grant = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_CLOSE: begin
            cmd.noact = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `VCA_ASSERT_IMPL(a_idle_emits_nothing, clock, reset, !busy, !(cmd.stop_step || cmd.steal || cmd.grant || cmd.reject || cmd.noact), "result command issued while idle")

endmodule

>>> sv/vca_datapath.sv
// Channel table, scan vectors and result register for the allocator.
// Depends on vca_pkg and the assertion macro header; driven by vca_ctrl.
`include "voice_channel_allocator_unit_macros.svh"

module vca_datapath import vca_pkg::*; #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_in,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             cfg_we,
   input  logic [CFG_W-1:0] cfg_wdata,
   output logic             rsp_valid,
   output rsp_type          rsp_out
);

   localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CFG_W-1:0] NumCh = CFG_W'(NUM_CHANNELS);

   function automatic logic [NUM_CHANNELS-1:0] first_one(input logic [NUM_CHANNELS-1:0] v);
      return v & (~v + NUM_CHANNELS'(1));
   endfunction

   function automatic logic [IdxW-1:0] encode(input logic [NUM_CHANNELS-1:0] oh);
      logic [IdxW-1:0] idx;
      idx = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (oh[c]) idx = idx | IdxW'(c);
      end
      return idx;
   endfunction

   // table
   logic [NUM_CHANNELS-1:0] busy_ff, busy_in;
   logic [15:0]             source_ff [NUM_CHANNELS];
   logic [7:0]              sound_ff  [NUM_CHANNELS];
   logic [7:0]              prio_ff   [NUM_CHANNELS];

   logic [CFG_W-1:0]        cfg_ff;
   req_type                 req_ff;

   logic [NUM_CHANNELS-1:0] stop_mask_ff, stop_mask_in;
   logic [NUM_CHANNELS-1:0] prio_hit_ff;
   logic [NUM_CHANNELS-1:0] pick_ff;
   logic                    found_ff, steal_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [CFG_W-1:0]        eff;
   logic [NUM_CHANNELS-1:0] inrange, match_v, rel_v, prio_hit, free_v;
   logic [NUM_CHANNELS-1:0] low, sel_oh;
   logic [IdxW-1:0]         sel_idx;
   logic                    stop_one;

   assign eff = (cfg_ff > NumCh) ? NumCh : cfg_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         inrange[c]  = (CFG_W'(c) < eff);
         match_v[c]  = busy_ff[c] & inrange[c] & (source_ff[c] == req_ff.source_id);
         rel_v[c]    = busy_ff[c] & inrange[c] & (CHAN_W'(c) == req_ff.chan_sel);
         prio_hit[c] = inrange[c] & (prio_ff[c] >= req_ff.prio);
         free_v[c]   = ~busy_ff[c] & inrange[c];
      end
   end

   assign low      = first_one(stop_mask_ff);
   assign stop_one = ((stop_mask_ff & (stop_mask_ff - NUM_CHANNELS'(1))) == '0);
   assign sel_oh   = cmd.stop_step ? low : pick_ff;
   assign sel_idx  = encode(sel_oh);

   always_comb begin
      stop_mask_in = stop_mask_ff;
      if (cmd.match) begin
         case (req_ff.func)
            FUNC_START:    stop_mask_in = first_one(match_v);
            FUNC_STOP_SRC: stop_mask_in = first_one(match_v);
            FUNC_RELEASE:  stop_mask_in = rel_v;
            FUNC_STOP_ALL: stop_mask_in = busy_ff & inrange;
            default:       stop_mask_in = '0;
         endcase
      end else if (cmd.stop_step) begin
         stop_mask_in = stop_mask_ff & ~low;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (cmd.stop_step) busy_in = busy_in & ~low;
      if (cmd.steal)     busy_in = busy_in & ~pick_ff;
      if (cmd.grant)     busy_in = busy_in | pick_ff;
   end

   always_comb begin
      rsp_valid_in = cmd.stop_step | cmd.steal | cmd.grant | cmd.reject | cmd.noact;
      rsp_in       = rsp_ff;
      if (cmd.stop_step || cmd.steal) begin
         rsp_in.kind      = KIND_STOPPED;
         rsp_in.chan_out  = CHAN_W'(sel_idx);
         rsp_in.sound_out = sound_ff[sel_idx];
         // only a stop-type command ends on a stopped item
         rsp_in.last      = cmd.stop_step & stop_one & (req_ff.func != FUNC_START);
      end else if (cmd.grant) begin
         rsp_in.kind      = KIND_GRANTED;
         rsp_in.chan_out  = CHAN_W'(sel_idx);
         rsp_in.sound_out = req_ff.sound_id;
         rsp_in.last      = 1'b1;
      end else if (cmd.reject || cmd.noact) begin
         rsp_in.kind      = cmd.reject ? KIND_REJECTED : KIND_NO_ACTION;
         rsp_in.chan_out  = '0;
         rsp_in.sound_out = '0;
         rsp_in.last      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_we) cfg_ff <= cfg_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      stop_mask_ff <= stop_mask_in;
      if (cmd.load) req_ff <= req_in;
      if (cmd.match) prio_hit_ff <= prio_hit;
      if (cmd.find) begin
         // free channel first, else steal by priority
         pick_ff  <= (|free_v) ? first_one(free_v) : first_one(prio_hit_ff);
         found_ff <= (|free_v) | (|prio_hit_ff);
         steal_ff <= ~(|free_v);
      end
      if (cmd.grant) begin
         source_ff[sel_idx] <= req_ff.source_id;
         sound_ff[sel_idx]  <= req_ff.sound_id;
         prio_ff[sel_idx]   <= req_ff.prio;
      end
   end

   assign status.stop_any = |stop_mask_ff;
   assign status.stop_one = stop_one;
   assign status.is_start = (req_ff.func == FUNC_START);
   assign status.found    = found_ff;
   assign status.steal    = steal_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

   `VCA_ASSERT_NEXT(a_grant_marks_busy, clock, reset, cmd.grant, (busy_ff & pick_ff) == pick_ff, "granted channel not marked busy")
   `VCA_ASSERT_NEXT(a_stop_gives_item, clock, reset, cmd.stop_step, rsp_valid_ff && (rsp_ff.kind == KIND_STOPPED), "stop step gave no stopped item")
   `VCA_ASSERT_IMPL(a_item_has_cause, clock, reset, rsp_valid_ff, $past(rsp_valid_in), "result item without a command")

endmodule

>>> sv/voice_channel_allocator_unit.sv
// Voice channel allocator: top level joining the sequencer and the channel table.
// Depends on vca_pkg, vca_ctrl and vca_datapath.
//
//  channel   ports                          handshake
//  --------  -----------------------------  -----------------------------------
//  command   start, busy, req_item          taken when start && !busy
//  result    rsp_strobe, rsp_item           strobe marks each item, cannot stall
//  config    csr_valid, csr_ready, csr_wdata written when csr_valid && csr_ready
//
// Start: stop the source's channel if any, then grant a free or stolen
// channel, or reject. Stop by source or release stops one channel, stop all
// each busy one; with nothing to stop, they give a no-action item.
// Each sequencer state handles one scan step or item. Results are registered.
// Synchronous reset frees every channel and sets the channel count to 8.
module voice_channel_allocator_unit import vca_pkg::*; #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   output logic             rsp_strobe,
   output rsp_type          rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   vca_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   vca_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_in    (req_item),
      .cmd       (cmd),
      .status    (status),
      .cfg_we    (csr_valid & csr_ready),
      .cfg_wdata (csr_wdata),
      .rsp_valid (rsp_strobe),
      .rsp_out   (rsp_item)
   );

endmodule
